// File: design/mia_pkg.sv
// Shared types and tables for the 4x4 matrix inverse block.
// Depends on nothing; the top level and the multiply-accumulate unit import it.
package mia_pkg;

  // Controls for one multiply-accumulate operation.
  typedef struct packed {
    logic go;
    logic sub;
    logic clr;
  } mac_ctl_t;

  // One step of a cofactor: operand positions inside the 3x3 minor, given as
  // indexes into the lists of kept rows and kept columns.
  typedef struct packed {
    logic [1:0] xr;
    logic [1:0] xc;
    logic [1:0] yr;
    logic [1:0] yc;
    logic       x_is_m;
    logic [1:0] m_sel;
    logic       sub;
    logic       clr;
  } step_t;

  localparam logic [3:0] StepOuterFirst = 4'd6;
  localparam logic [3:0] StepLast       = 4'd8;

  // The first six steps form the three 2x2 minors of the lower two rows, the
  // last three weight them by the top row of the 3x3 minor.
  function automatic step_t step_tab(input logic [3:0] j);
    step_t s;
    s = '0;
    unique case (j)
      4'd0: begin s.xr = 2'd1; s.xc = 2'd1; s.yr = 2'd2; s.yc = 2'd2; s.clr = 1'b1; end
      4'd1: begin s.xr = 2'd1; s.xc = 2'd2; s.yr = 2'd2; s.yc = 2'd1; s.sub = 1'b1; end
      4'd2: begin s.xr = 2'd1; s.xc = 2'd0; s.yr = 2'd2; s.yc = 2'd2; s.clr = 1'b1; end
      4'd3: begin s.xr = 2'd1; s.xc = 2'd2; s.yr = 2'd2; s.yc = 2'd0; s.sub = 1'b1; end
      4'd4: begin s.xr = 2'd1; s.xc = 2'd0; s.yr = 2'd2; s.yc = 2'd1; s.clr = 1'b1; end
      4'd5: begin s.xr = 2'd1; s.xc = 2'd1; s.yr = 2'd2; s.yc = 2'd0; s.sub = 1'b1; end
      4'd6: begin s.x_is_m = 1'b1; s.m_sel = 2'd0; s.yc = 2'd0; s.clr = 1'b1; end
      4'd7: begin s.x_is_m = 1'b1; s.m_sel = 2'd1; s.yc = 2'd1; s.sub = 1'b1; end
      4'd8: begin s.x_is_m = 1'b1; s.m_sel = 2'd2; s.yc = 2'd2; end
      default: s = '0;
    endcase
    return s;
  endfunction

  // The i-th index among 0..3 once index ex is left out.
  function automatic logic [1:0] skip_idx(input logic [1:0] ex, input logic [1:0] i);
    return (i < ex) ? i : i + 2'd1;
  endfunction

endpackage

// File: design/matrix_inverse_4x4.sv
// Top level of the 4x4 matrix inverse: element store, sequencer, cofactor store.
// Depends on mia_pkg, mia_mac and mia_div.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+-----------------------------
//  input    | in_element_value                        | start && !busy
//  result   | out_result_value, out_result_index,     | out_strobe, one cycle each,
//           | out_last_element, out_singular,         | no back pressure
//           | out_saturated                           |
//
// Elements load one per cycle. After the sixteenth, one bit-serial multiply-accumulate
// unit runs 9 operations per cofactor and 4 for the determinant. Then one restoring
// divider works out each element in turn; a singular matrix skips the divider.
// busy is high from the sixteenth element until the last result is out.
// Reset is synchronous and active low; the element store needs none.
module matrix_inverse_4x4 import mia_pkg::*; #(
  parameter int ELEMENT_BITS  = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [ELEMENT_BITS-1:0] in_element_value,
  output logic                           out_strobe,
  output logic signed [ELEMENT_BITS-1:0] out_result_value,
  output logic [3:0]                     out_result_index,
  output logic                           out_last_element,
  output logic                           out_singular,
  output logic                           out_saturated
);

  localparam int W   = ELEMENT_BITS;
  localparam int F   = FRACTION_BITS;
  localparam int AW  = 4 * W + 2;  // determinant and accumulator
  localparam int CFW = 3 * W + 1;  // signed cofactor
  localparam int MW  = 3 * W;      // cofactor magnitude
  localparam int PW  = 2 * W + 1;  // signed 2x2 minor

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_COF_X    = 8'b0000_0010,
    S_COF_GO   = 8'b0000_0100,
    S_COF_WAIT = 8'b0000_1000,
    S_DET_X    = 8'b0001_0000,
    S_DET_GO   = 8'b0010_0000,
    S_DET_WAIT = 8'b0100_0000,
    S_DIV      = 8'b1000_0000
  } state_t;

  state_t         state_r;
  logic [3:0]     load_cnt_r;
  logic [W-1:0]   store_r [16];
  logic [CFW-1:0] cof_r [16];
  logic [PW-1:0]  minor_r [3];
  logic [3:0]     k_r;
  logic [3:0]     j_r;
  logic [1:0]     i_r;
  logic           div_run_r;
  logic [AW-1:0]  xop_r;
  logic [AW-1:0]  det_abs_r;
  logic           det_neg_r;
  logic           singular_r;
  logic           cof_neg_r;

  logic           out_strobe_r;
  logic [W-1:0]   out_value_r;
  logic [3:0]     out_index_r;
  logic           out_last_r;
  logic           out_singular_r;
  logic           out_sat_r;

  step_t          st;
  logic [1:0]     row, col;
  logic [3:0]     st_addr;
  logic [3:0]     cof_addr;
  logic [W-1:0]   st_data;
  logic [CFW-1:0] cof_data;
  mac_ctl_t       mac_ctl;
  logic           mac_done;
  logic [AW-1:0]  mac_acc;
  logic           div_go;
  logic [MW-1:0]  div_num;
  logic           div_done;
  logic [W:0]     div_quo;
  logic           div_ovf;
  logic           div_rnd;
  logic [W+1:0]   q_round;
  logic [W+1:0]   q_lim;
  logic           res_neg;
  logic           res_sat;
  logic [W-1:0]   res_val;

  // Cofactor of element (row, col) lands at adjugate position k, transposed.
  assign st  = step_tab(j_r);
  assign row = k_r[3:2];
  assign col = k_r[1:0];

  // One read address for the element store and one for the cofactor store.
  always_comb begin
    unique case (state_r)
      S_COF_X:  st_addr = {skip_idx(col, st.xc), skip_idx(row, st.xr)};
      S_DET_GO: st_addr = {2'b00, i_r};
      default:  st_addr = {skip_idx(col, st.yc), skip_idx(row, st.yr)};
    endcase
  end
  assign st_data  = store_r[st_addr];
  assign cof_addr = (state_r == S_DET_X) ? {i_r, 2'b00} : k_r;
  assign cof_data = cof_r[cof_addr];

  always_comb begin
    mac_ctl = '0;
    if (state_r == S_COF_GO) begin
      mac_ctl.go  = 1'b1;
      mac_ctl.clr = st.clr;
      // The checkerboard sign of the cofactor is folded into the outer steps.
      mac_ctl.sub = st.sub ^ (st.x_is_m & (row[0] ^ col[0]));
    end else if (state_r == S_DET_GO) begin
      mac_ctl.go  = 1'b1;
      mac_ctl.clr = (i_r == 2'd0);
    end
  end

  mia_mac #(.W(W), .AW(AW)) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .x     (xop_r),
    .y     (st_data),
    .done  (mac_done),
    .acc   (mac_acc)
  );

  assign div_go  = (state_r == S_DIV) && !div_run_r && !singular_r;
  assign div_num = cof_data[CFW-1] ? MW'(CFW'(0) - cof_data) : cof_data[MW-1:0];

  mia_div #(.W(W), .F(F), .MW(MW), .DW(AW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .num   (div_num),
    .den   (det_abs_r),
    .done  (div_done),
    .quo   (div_quo),
    .ovf   (div_ovf),
    .rnd   (div_rnd)
  );

  // Rounding and saturation of the finished quotient.
  assign res_neg = cof_neg_r ^ det_neg_r;
  assign q_round = (W + 2)'(div_quo) + (W + 2)'(div_rnd);
  assign q_lim   = res_neg ? ((W + 2)'(1) << (W - 1)) : (((W + 2)'(1) << (W - 1)) - 1'b1);
  assign res_sat = div_ovf || (q_round > q_lim);
  always_comb begin
    if (res_sat) begin
      res_val = q_lim[W-1:0];
    end else if (res_neg) begin
      res_val = W'(0) - q_round[W-1:0];
    end else begin
      res_val = q_round[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      load_cnt_r   <= '0;
      k_r          <= '0;
      j_r          <= '0;
      i_r          <= '0;
      div_run_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            store_r[load_cnt_r] <= in_element_value;
            load_cnt_r          <= load_cnt_r + 1'b1;
            if (load_cnt_r == 4'd15) begin
              k_r     <= '0;
              j_r     <= '0;
              state_r <= S_COF_X;
            end
          end
        end
        S_COF_X: begin
          xop_r   <= st.x_is_m ? AW'($signed(minor_r[st.m_sel])) : AW'($signed(st_data));
          state_r <= S_COF_GO;
        end
        S_COF_GO: begin
          state_r <= S_COF_WAIT;
        end
        S_COF_WAIT: begin
          if (mac_done) begin
            if (j_r[0] && (j_r < StepOuterFirst)) begin
              minor_r[j_r[2:1]] <= mac_acc[PW-1:0];
            end
            if (j_r == StepLast) begin
              cof_r[k_r] <= mac_acc[CFW-1:0];
              j_r        <= '0;
              if (k_r == 4'd15) begin
                i_r     <= '0;
                state_r <= S_DET_X;
              end else begin
                k_r     <= k_r + 1'b1;
                state_r <= S_COF_X;
              end
            end else begin
              j_r     <= j_r + 1'b1;
              state_r <= S_COF_X;
            end
          end
        end
        S_DET_X: begin
          xop_r   <= AW'($signed(cof_data));
          state_r <= S_DET_GO;
        end
        S_DET_GO: begin
          state_r <= S_DET_WAIT;
        end
        S_DET_WAIT: begin
          if (mac_done) begin
            if (i_r == 2'd3) begin
              det_neg_r  <= mac_acc[AW-1];
              det_abs_r  <= mac_acc[AW-1] ? AW'(0) - mac_acc : mac_acc;
              singular_r <= (mac_acc == '0);
              k_r        <= '0;
              state_r    <= S_DIV;
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= S_DET_X;
            end
          end
        end
        S_DIV: begin
          if (singular_r || div_done) begin
            // A singular matrix skips the divider and gives zeros.
            out_strobe_r   <= 1'b1;
            out_value_r    <= singular_r ? '0 : res_val;
            out_sat_r      <= singular_r ? 1'b0 : res_sat;
            out_singular_r <= singular_r;
            out_index_r    <= k_r;
            out_last_r     <= (k_r == 4'd15);
            div_run_r      <= 1'b0;
            k_r            <= k_r + 1'b1;
            if (k_r == 4'd15) begin
              state_r <= S_IDLE;
            end
          end else if (!div_run_r) begin
            cof_neg_r <= cof_data[CFW-1];
            div_run_r <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_strobe       = out_strobe_r;
  assign out_result_value = out_value_r;
  assign out_result_index = out_index_r;
  assign out_last_element = out_last_r;
  assign out_singular     = out_singular_r;
  assign out_saturated    = out_sat_r;

endmodule

// File: design/mia_mac.sv
// Bit-serial signed multiply-accumulate unit, one multiplier bit per cycle.
// Depends on mia_pkg for the control struct.
module mia_mac import mia_pkg::*; #(
  parameter int W  = 32,
  parameter int AW = 130
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mac_ctl_t             ctl,
  input  logic signed [AW-1:0] x,
  input  logic signed [W-1:0]  y,
  output logic                 done,
  output logic [AW-1:0]        acc
);

  localparam int CW = $clog2(W);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [AW-1:0] xs_r;
  logic [W-1:0]  ys_r;
  logic          sub_r;
  logic [AW-1:0] acc_r;
  logic          neg;

  // The sign bit of y carries negative weight.
  assign neg = sub_r ^ (cnt_r == CW'(W - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        xs_r   <= x;
        ys_r   <= y;
        sub_r  <= ctl.sub;
        if (ctl.clr) begin
          acc_r <= '0;
        end
      end else if (busy_r) begin
        if (ys_r[0]) begin
          acc_r <= neg ? acc_r - xs_r : acc_r + xs_r;
        end
        xs_r  <= xs_r << 1;
        ys_r  <= ys_r >> 1;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign acc  = acc_r;

endmodule

// File: design/mia_div.sv
// Restoring divider, one quotient bit per cycle, with overflow tracking.
// Self-contained; the top level uses it for every inverse element of a nonsingular matrix.
module mia_div #(
  parameter int W  = 32,
  parameter int F  = 16,
  parameter int MW = 96,
  parameter int DW = 130
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [MW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [W:0]    quo,
  output logic          ovf,
  output logic          rnd
);

  localparam int NB = MW + 2 * F;
  localparam int NC = $clog2(NB);

  logic          busy_r;
  logic          done_r;
  logic [NC-1:0] cnt_r;
  logic [NB-1:0] n_r;
  logic [DW-1:0] den_r;
  logic [DW-1:0] rem_r;
  logic [W:0]    q_r;
  logic          ovf_r;
  logic [DW:0]   rem2;
  logic [DW:0]   diff;
  logic          ge;

  assign rem2 = {rem_r, n_r[NB-1]};
  assign diff = rem2 - {1'b0, den_r};
  assign ge   = rem2 >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        n_r    <= NB'(num) << (2 * F);
        den_r  <= den;
        rem_r  <= '0;
        q_r    <= '0;
        ovf_r  <= 1'b0;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DW-1:0] : rem2[DW-1:0];
        q_r   <= {q_r[W-1:0], ge};
        ovf_r <= ovf_r | q_r[W];
        n_r   <= n_r << 1;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == NC'(NB - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;
  assign ovf  = ovf_r;
  // Round half up: twice the remainder against the divisor.
  assign rnd  = {rem_r, 1'b0} >= {1'b0, den_r};

endmodule

// File: design/mia_checker.sv
// Port-level checks for the 4x4 matrix inverse and the bind that attaches them.
// Depends on matrix_inverse_4x4 being compiled first.
module mia_checker #(
  parameter int ELEMENT_BITS = 32
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    busy,
  input logic                    out_strobe,
  input logic [ELEMENT_BITS-1:0] out_result_value,
  input logic [3:0]              out_result_index,
  input logic                    out_last_element,
  input logic                    out_singular,
  input logic                    out_saturated
);

  // The last item of a run is always at position fifteen.
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last_element |-> out_result_index == 4'd15)
    else $error("last result not at index 15");

  // A singular matrix gives clean zeros.
  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_singular |-> (out_result_value == '0) && !out_saturated)
    else $error("singular result not zero");

  // The block stays busy until the last result of a run.
  a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_element |-> busy)
    else $error("not busy in the middle of a run");

  // Back-to-back results count up by one.
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && $past(out_strobe) && !$past(out_last_element)
      |-> out_result_index == 4'($past(out_result_index) + 4'd1))
    else $error("result index skipped");

endmodule

bind matrix_inverse_4x4 mia_checker #(.ELEMENT_BITS(ELEMENT_BITS)) u_mia_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .busy             (busy),
  .out_strobe       (out_strobe),
  .out_result_value (out_result_value),
  .out_result_index (out_result_index),
  .out_last_element (out_last_element),
  .out_singular     (out_singular),
  .out_saturated    (out_saturated)
);

// File: tb/matrix_inverse_4x4_test.sv
// Self-checking testbench for matrix_inverse_4x4: it streams whole 4x4 matrices and
// predicts each inverse exactly with wide integers. Depends on the RTL.
module matrix_inverse_4x4_test;

  localparam int EW = 32;
  localparam int FW = 16;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [EW-1:0] in_element_value;
  logic out_strobe;
  logic signed [EW-1:0] out_result_value;
  logic [3:0] out_result_index;
  logic out_last_element;
  logic out_singular;
  logic out_saturated;

  // One expected inverse element.
  typedef struct {
    logic [EW-1:0] value;
    logic [3:0]    index;
    logic          last;
    logic          singular;
    logic          saturated;
  } inverse_elem_t;

  inverse_elem_t inverse_q[$];
  logic [EW-1:0] loaded[16];
  logic [3:0]    load_count;
  logic [EW-1:0] mat[16];
  int errors;
  int cycles;
  int matrices_sent;
  int singular_seen;
  int saturated_seen;

  matrix_inverse_4x4 #(.ELEMENT_BITS(EW), .FRACTION_BITS(FW)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_element_value(in_element_value),
    .out_strobe(out_strobe),
    .out_result_value(out_result_value),
    .out_result_index(out_result_index),
    .out_last_element(out_last_element),
    .out_singular(out_singular),
    .out_saturated(out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Element at (row, col) of the loaded matrix, sign-extended to full width.
  function automatic logic signed [255:0] entry(input int row, input int col);
    return 256'(signed'(loaded[(row + 4 * col) & 15]));
  endfunction

  // Signed cofactor of element (row, col), exact.
  function automatic logic signed [255:0] cofactor_of(input int row, input int col);
    int rs[3];
    int cs[3];
    int n;
    logic signed [255:0] a[3][3];
    logic signed [255:0] acc;
    n = 0;
    for (int i = 0; i < 4; i++) if (i != row) begin rs[n] = i; n++; end
    n = 0;
    for (int i = 0; i < 4; i++) if (i != col) begin cs[n] = i; n++; end
    for (int i = 0; i < 9; i++) a[i / 3][i % 3] = entry(rs[i / 3], cs[i % 3]);
    acc = a[0][0] * (a[1][1] * a[2][2] - a[1][2] * a[2][1])
        - a[0][1] * (a[1][0] * a[2][2] - a[1][2] * a[2][0])
        + a[0][2] * (a[1][0] * a[2][1] - a[1][1] * a[2][0]);
    return ((row + col) & 1) ? -acc : acc;
  endfunction

  // Takes one accepted element; the sixteenth queues the whole expected inverse.
  task automatic absorb_element(input logic [EW-1:0] v);
    logic signed [255:0] adj[16];
    logic signed [255:0] det;
    logic [255:0] num;
    logic [255:0] dabs;
    logic [255:0] quo;
    logic [255:0] rem;
    logic [255:0] lim;
    logic neg;
    inverse_elem_t e;
    loaded[load_count] = v;
    load_count = load_count + 4'd1;
    if (load_count != 4'd0) return;
    for (int k = 0; k < 16; k++) adj[k] = cofactor_of(k >> 2, k & 3);
    det = '0;
    for (int i = 0; i < 4; i++) det = det + entry(i, 0) * adj[4 * i];
    dabs = det[255] ? 256'(-det) : 256'(det);
    for (int k = 0; k < 16; k++) begin
      e.value = '0;
      e.index = 4'(k);
      e.last = (k == 15);
      e.singular = (det == 0);
      e.saturated = 1'b0;
      if (det != 0) begin
        neg = adj[k][255] ^ det[255];
        num = (adj[k][255] ? 256'(-adj[k]) : 256'(adj[k])) << (2 * FW);
        quo = num / dabs;
        rem = num % dabs;
        // Round to nearest, ties away from zero.
        if ((rem << 1) >= dabs) quo = quo + 1;
        lim = neg ? (256'(1) << (EW - 1)) : ((256'(1) << (EW - 1)) - 1);
        if (quo > lim) begin
          e.value = EW'(lim);
          if (neg) e.value = {1'b1, {(EW - 1){1'b0}}};
          e.saturated = 1'b1;
        end else begin
          e.value = neg ? EW'(-quo) : EW'(quo);
        end
      end
      inverse_q.push_back(e);
    end
  endtask

  // Idle cycles before an element: mostly none, sometimes a few, rarely many.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // Sends one element: drives start at a falling edge where busy is low, so the
  // item is taken at the next rising edge.
  task automatic send_element(input logic [EW-1:0] v, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    while (busy) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_element_value <= v;
    @(posedge clk);
    absorb_element(v);
    @(negedge clk);
  endtask

  // Streams the matrix in mat[] in storage order.
  task automatic send_matrix(input bit with_gaps);
    for (int k = 0; k < 16; k++) send_element(mat[k], with_gaps ? pick_gap() : 0);
    matrices_sent++;
  endtask

  task automatic set_diag(input logic [EW-1:0] d0, input logic [EW-1:0] d1,
                          input logic [EW-1:0] d2, input logic [EW-1:0] d3);
    for (int k = 0; k < 16; k++) mat[k] = '0;
    mat[0] = d0;
    mat[5] = d1;
    mat[10] = d2;
    mat[15] = d3;
  endtask

  // Identity and a scaled matrix with one off-diagonal entry, with an exact inverse.
  task automatic test_identity();
    set_diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_matrix(1'b0);
    set_diag(32'h0002_0000, 32'hFFFC_0000, 32'h0000_8000, 32'h0001_0000);
    mat[4] = 32'h0000_4000;
    send_matrix(1'b1);
  endtask

  // A zero matrix has a zero determinant and must flag singular.
  task automatic test_singular();
    set_diag('0, '0, '0, '0);
    send_matrix(1'b0);
  endtask

  // Tiny pivots push the inverse past both ends of the range.
  task automatic test_saturation();
    set_diag(32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0001_0000);
    send_matrix(1'b1);
  endtask

  // Extreme element values in all but two places, including the most negative one.
  task automatic test_extremes();
    for (int k = 0; k < 16; k++) mat[k] = (k % 3 == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    mat[5] = 32'h0000_0000;
    mat[10] = 32'hFFFF_FFFF;
    send_matrix(1'b1);
  endtask

  // Random matrices of several shapes. Singular ones repeat a column.
  task automatic test_random(input int count);
    int shape;
    for (int m = 0; m < count; m++) begin
      shape = $urandom_range(0, 9);
      for (int k = 0; k < 16; k++) begin
        case (shape)
          0, 1, 2: mat[k] = $urandom();
          3, 4, 5: mat[k] = 32'(signed'($urandom_range(0, 1 << 19)) - (1 << 18));
          6, 7: mat[k] = (k % 5 == 0) ? 32'($urandom_range(1 << 16, 1 << 20))
                                       : 32'(signed'($urandom_range(0, 8191)) - 4096);
          default: mat[k] = 32'(signed'($urandom_range(0, 1 << 17)) - (1 << 16));
        endcase
      end
      if (shape >= 8) for (int r = 0; r < 4; r++) mat[8 + r] = mat[r];
      // Once, hold off until every queued result is out.
      if (m == count / 2) begin
        start <= 1'b0;
        while (inverse_q.size() != 0) @(negedge clk);
      end
      send_matrix(1'b1);
    end
  endtask

  // Compares each result with the oldest expected inverse element.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (inverse_q.size() == 0) begin
        $display("%0t: unexpected result index %0d value %h", $time, out_result_index,
                 out_result_value);
        errors++;
      end else begin
        inverse_elem_t e;
        e = inverse_q.pop_front();
        if (out_result_value !== e.value || out_result_index !== e.index ||
            out_last_element !== e.last || out_singular !== e.singular ||
            out_saturated !== e.saturated) begin
          $display("%0t: mismatch expected val=%h idx=%0d last=%b sing=%b sat=%b",
                   $time, e.value, e.index, e.last, e.singular, e.saturated);
          $display("%0t:          actual   val=%h idx=%0d last=%b sing=%b sat=%b",
                   $time, out_result_value, out_result_index, out_last_element,
                   out_singular, out_saturated);
          errors++;
        end
        if (e.singular && e.last) singular_seen++;
        if (e.saturated) saturated_seen++;
      end
    end
  end

  // Watchdog over the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    matrices_sent = 0;
    singular_seen = 0;
    saturated_seen = 0;
    load_count = '0;
    rst_n = 1'b0;
    start = 1'b0;
    in_element_value = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_identity();
    test_singular();
    test_saturation();
    test_extremes();
    test_random(16);
    start <= 1'b0;
    while (inverse_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("Sent %0d matrices; %0d singular, %0d clipped elements observed.",
             matrices_sent, singular_seen, saturated_seen);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
